@@ design/lcc_pkg.sv @@
package lcc_pkg;

  localparam int unsigned IN_W          = 63;
  localparam int unsigned NUM_DIGITS    = 19;
  localparam int unsigned BITS_PER_STEP = 3;
  localparam int unsigned CONV_STEPS    = IN_W / BITS_PER_STEP;
  localparam int unsigned STEP_CNT_W    = $clog2(CONV_STEPS);
  localparam int unsigned DIGIT_IDX_W   = $clog2(NUM_DIGITS);
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned GROUP_SIZE    = 5;
  localparam int unsigned NUM_GROUPS    = (NUM_DIGITS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned GROUP_SUM_W   = 6;
  localparam int unsigned TOTAL_SUM_W   = 8;

  localparam logic [COUNT_W-1:0] VISA_LEN_SHORT = 5'd13;
  localparam logic [COUNT_W-1:0] VISA_LEN_LONG  = 5'd16;
  localparam logic [COUNT_W-1:0] MC_LEN         = 5'd16;
  localparam logic [COUNT_W-1:0] AMEX_LEN       = 5'd15;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;

  typedef enum logic [1:0] {
    KIND_INVALID    = 2'd0,
    KIND_VISA       = 2'd1,
    KIND_MASTERCARD = 2'd2,
    KIND_AMEX       = 2'd3
  } kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0] digit_count;
    logic               luhn_pass;
    kind_t              card_kind;
  } result_t;

  // Luhn contribution of one digit; doubled positions fold 10..18 down to 1..9
  function automatic logic [3:0] luhn_term(input digit_t d, input logic doubled);
    logic [4:0] dd;
    dd = {d, 1'b0};
    if (!doubled) begin
      luhn_term = d;
    end else if (dd > 5'd9) begin
      luhn_term = 4'(dd - 5'd9);
    end else begin
      luhn_term = dd[3:0];
    end
  endfunction

endpackage

@@ design/lcc_digit_cell.sv @@
module lcc_digit_cell (
  input  logic                clk,
  input  logic                clr,
  input  logic                step,
  input  logic [2:0]          in_bits,   // bit 2 enters first
  output logic [2:0]          out_bits,  // bit 2 leaves first
  output lcc_pkg::digit_t     digit
);

  lcc_pkg::digit_t digit_r;
  lcc_pkg::digit_t digit_nxt;

  // Three shift-and-add-3 steps per cycle while step is high; each step hands its top bit up the row
  always_comb begin
    logic [3:0] d;
    logic [3:0] adj;
    d = digit_r;
    out_bits = '0;
    for (int j = 2; j >= 0; j--) begin
      adj = (d >= 4'd5) ? 4'(d + 4'd3) : d;
      out_bits[j] = adj[3];
      d = {adj[2:0], in_bits[j]};
    end
    digit_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      digit_r <= '0;
    end else if (step) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

@@ design/lcc_classify.sv @@
module lcc_classify (
  input  logic                clk,
  input  logic                load,
  input  lcc_pkg::digits_t    digits,
  output lcc_pkg::result_t    res
);

  logic [lcc_pkg::GROUP_SUM_W-1:0] grp_sum_r   [lcc_pkg::NUM_GROUPS];
  logic [lcc_pkg::GROUP_SUM_W-1:0] grp_sum_nxt [lcc_pkg::NUM_GROUPS];
  logic [lcc_pkg::DIGIT_IDX_W-1:0] hi_r, hi_nxt;
  lcc_pkg::digit_t                 lead_r, lead_nxt;
  lcc_pkg::digit_t                 second_r, second_nxt;

  logic [lcc_pkg::TOTAL_SUM_W-1:0] total;
  logic [lcc_pkg::COUNT_W-1:0]     count;
  logic                            pass;

  // First stage: partial Luhn sums, highest nonzero digit, leading digits
  always_comb begin
    int idx;
    for (int g = 0; g < lcc_pkg::NUM_GROUPS; g++) begin
      grp_sum_nxt[g] = '0;
      for (int k = 0; k < lcc_pkg::GROUP_SIZE; k++) begin
        idx = g * lcc_pkg::GROUP_SIZE + k;
        if (idx < lcc_pkg::NUM_DIGITS) begin
          grp_sum_nxt[g] = grp_sum_nxt[g] + lcc_pkg::GROUP_SUM_W'(
            lcc_pkg::luhn_term(digits[idx], idx[0]));
        end
      end
    end
    hi_nxt = '0;
    for (int i = 1; i < lcc_pkg::NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        hi_nxt = lcc_pkg::DIGIT_IDX_W'(i);
      end
    end
    lead_nxt   = digits[hi_nxt];
    second_nxt = (hi_nxt == '0) ? 4'd0 : digits[lcc_pkg::DIGIT_IDX_W'(hi_nxt - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_sum_r <= grp_sum_nxt;
      hi_r      <= hi_nxt;
      lead_r    <= lead_nxt;
      second_r  <= second_nxt;
    end
  end

  // Second stage: total, mod-10 test, prefix rules
  always_comb begin
    total = '0;
    for (int g = 0; g < lcc_pkg::NUM_GROUPS; g++) begin
      total = total + lcc_pkg::TOTAL_SUM_W'(grp_sum_r[g]);
    end
    pass  = total inside {8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80,
                          8'd90, 8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150,
                          8'd160, 8'd170};
    count = lcc_pkg::COUNT_W'(hi_r) + 1'b1;

    res.digit_count = count;
    res.luhn_pass   = pass;
    res.card_kind   = lcc_pkg::KIND_INVALID;
    if (pass) begin
      if ((count == lcc_pkg::VISA_LEN_SHORT || count == lcc_pkg::VISA_LEN_LONG)
          && lead_r == 4'd4) begin
        res.card_kind = lcc_pkg::KIND_VISA;
      end else if (count == lcc_pkg::MC_LEN && lead_r == 4'd5
                   && second_r inside {[4'd1:4'd5]}) begin
        res.card_kind = lcc_pkg::KIND_MASTERCARD;
      end else if (count == lcc_pkg::AMEX_LEN && lead_r == 4'd3
                   && second_r inside {4'd4, 4'd7}) begin
        res.card_kind = lcc_pkg::KIND_AMEX;
      end
    end
  end

endmodule

@@ design/luhn_card_number_classifier_unit.sv @@
// Luhn card number classifier.
// Input stream: in_tdata carries one card number per transaction (bits 62:0,
// bit 63 ignored). Output stream: out_tdata carries one result per card number.
// A row of 19 BCD digit cells converts the number three bits per cycle with
// shift-and-add-3, each cell passing its overflow bits to the next one up.
// After 21 conversion steps a two-stage classifier forms the Luhn sum, the
// digit count and the leading digits, and the result is loaded into the
// output register.
// One card number is in work at a time; a new one is taken only after the
// current one has passed the cell row and the classifier stages and its
// result has been loaded into the output register.
// in_tready is high while the unit is idle, even when a result is still
// waiting in the output register. When the receiver stalls with a result
// pending and the next one is finished, that one waits inside until the
// register frees up.
// Reset (rst_n low, synchronous) empties the output register and returns the
// unit to idle; no clearing pass is needed.
module luhn_card_number_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [62:0] card_number, [63] zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] card_kind, [2] luhn_pass, [7:3] digit_count
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [lcc_pkg::STEP_CNT_W-1:0]    step_cnt_r, step_cnt_nxt;
  logic [lcc_pkg::IN_W-1:0]          bin_r, bin_nxt;
  logic                              out_valid_r, out_valid_nxt;
  lcc_pkg::result_t                  out_res_r, out_res_nxt;

  logic                              in_xfer;
  logic                              cell_step;
  logic                              out_load;
  logic [2:0]                        chain_bits [lcc_pkg::NUM_DIGITS+1];
  lcc_pkg::digits_t                  digits;
  lcc_pkg::result_t                  cls_res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cell_step = (state_r == ST_CONV);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Feed the row from the top of the binary word, most significant bit first
  assign chain_bits[0] = bin_r[lcc_pkg::IN_W-1 -: lcc_pkg::BITS_PER_STEP];

  for (genvar i = 0; i < lcc_pkg::NUM_DIGITS; i++) begin : g_cell
    lcc_digit_cell u_cell (
      .clk      (clk),
      .clr      (in_xfer),
      .step     (cell_step),
      .in_bits  (chain_bits[i]),
      .out_bits (chain_bits[i+1]),
      .digit    (digits[i])
    );
  end

  lcc_classify u_classify (
    .clk    (clk),
    .load   (state_r == ST_SUM),
    .digits (digits),
    .res    (cls_res)
  );

  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          bin_nxt      = in_tdata[lcc_pkg::IN_W-1:0];
          step_cnt_nxt = '0;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        bin_nxt      = {bin_r[lcc_pkg::IN_W-lcc_pkg::BITS_PER_STEP-1:0],
                        lcc_pkg::BITS_PER_STEP'(0)};
        step_cnt_nxt = lcc_pkg::STEP_CNT_W'(step_cnt_r + 1'b1);
        if (step_cnt_r == lcc_pkg::STEP_CNT_W'(lcc_pkg::CONV_STEPS - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_load) begin
          out_res_nxt   = cls_res;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_cnt_r  <= step_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  // Top cell must never overflow: 2^63 - 1 has nineteen digits
  a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (chain_bits[lcc_pkg::NUM_DIGITS] == 3'd0))
    else $error("digit row overflowed past the top cell");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.digit_count >= 5'd1 && out_res_r.digit_count <= 5'd19))
    else $error("digit count out of range");

  a_kind_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.card_kind != lcc_pkg::KIND_INVALID) |-> out_res_r.luhn_pass)
    else $error("card kind set on a failing Luhn check");

endmodule
